// ===== hw/rtl/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Types, codes and reset values shared by the relay cut sequencer files.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int CFG_W             = 10;
  localparam int TIMER_WIDTH_DEF   = 10;
  localparam int CFG_IDX_W         = 2;

  localparam logic [CFG_W-1:0] CUT_TIME_RST     = CFG_W'(40);
  localparam logic [CFG_W-1:0] SAFETY_LIMIT_RST = CFG_W'(100);
  localparam logic [CFG_W-1:0] COOLDOWN_RST     = CFG_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_CUT_TIME     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY_LIMIT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_CUT      = 3'd1,
    PH_COOLDOWN = 3'd2,
    PH_WAIT     = 3'd3,
    PH_FAULT    = 3'd4
  } phase_t;

  typedef struct packed {
    logic ms_tick;
    logic press_event;
    logic button_held;
  } in_t;

  typedef struct packed {
    logic       relay_drive;
    logic [2:0] phase_code;
    logic       shift_beep;
    logic       fault_pulse;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] cut_time_ms;
    logic [CFG_W-1:0] safety_limit_ms;
    logic [CFG_W-1:0] cooldown_ms;
  } cfg_t;

endpackage

// ===== hw/rtl/relay_cut_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// relay_cut_sequencer_core
// Poll-driven sequencer for a relay shift cut with safety fault latch.
// ----------------------------------------------------------------------------
// One poll item is taken per clock cycle when the result side keeps up. A
// poll lands in an input register; once the result register is free, the phase
// logic runs on it, updates the phase and timers and loads the result register.
// The result register only stalls the input register when a result is still
// waiting to be taken.
// Configuration writes take effect at the next clock edge.
module relay_cut_sequencer_core import rcs_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t                   cfg;
  logic                   s1_valid;
  in_t                    s1_item;
  logic                   s1_adv;
  phase_t                 phase;
  phase_t                 phase_next;
  logic [TIMER_WIDTH-1:0] cut_elapsed;
  logic [TIMER_WIDTH-1:0] cut_elapsed_next;
  logic [TIMER_WIDTH-1:0] cooldown_elapsed;
  logic [TIMER_WIDTH-1:0] cooldown_elapsed_next;
  out_t                   result;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cut_time_ms     <= CUT_TIME_RST;
      cfg.safety_limit_ms <= SAFETY_LIMIT_RST;
      cfg.cooldown_ms     <= COOLDOWN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUT_TIME:     cfg.cut_time_ms     <= cfg_wdata;
        REG_SAFETY_LIMIT: cfg.safety_limit_ms <= cfg_wdata;
        REG_COOLDOWN:     cfg.cooldown_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  rcs_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .phase                 (phase),
    .cut_elapsed           (cut_elapsed),
    .cooldown_elapsed      (cooldown_elapsed),
    .cfg                   (cfg),
    .item                  (s1_item),
    .phase_next            (phase_next),
    .cut_elapsed_next      (cut_elapsed_next),
    .cooldown_elapsed_next (cooldown_elapsed_next),
    .result                (result)
  );

  // state moves only when the item's result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      cut_elapsed      <= '0;
      cooldown_elapsed <= '0;
    end else if (s1_adv) begin
      phase            <= phase_next;
      cut_elapsed      <= cut_elapsed_next;
      cooldown_elapsed <= cooldown_elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

  // fault is latched until reset
  a_fault_latched: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FAULT) |=> (phase == PH_FAULT))
    else $error("fault phase left without reset");

  a_fault_pulse_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.fault_pulse) |-> (out_data.phase_code == PH_FAULT))
    else $error("fault pulse outside fault phase");

  a_beep_starts_cut: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.shift_beep) |-> (out_data.relay_drive &&
      (out_data.phase_code == PH_CUT)))
    else $error("beep without cut start");

endmodule

// ===== hw/rtl/rcs_step.sv =====
// ----------------------------------------------------------------------------
// rcs_step
// Next-state and result logic for one poll of the cut sequencer.
// ----------------------------------------------------------------------------
module rcs_step import rcs_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  phase_t                 phase,
  input  logic [TIMER_WIDTH-1:0] cut_elapsed,
  input  logic [TIMER_WIDTH-1:0] cooldown_elapsed,
  input  cfg_t                   cfg,
  input  in_t                    item,
  output phase_t                 phase_next,
  output logic [TIMER_WIDTH-1:0] cut_elapsed_next,
  output logic [TIMER_WIDTH-1:0] cooldown_elapsed_next,
  output out_t                   result
);

  // compare width covers both the timer and the register
  localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  logic [TIMER_WIDTH-1:0] cut_cnt;
  logic [TIMER_WIDTH-1:0] cool_cnt;
  logic                   safety_hit;
  logic                   cut_done;
  logic                   cool_done;

  // saturating count on tick
  assign cut_cnt  = (item.ms_tick && (cut_elapsed != '1)) ?
                    cut_elapsed + TIMER_WIDTH'(1) : cut_elapsed;
  assign cool_cnt = (item.ms_tick && (cooldown_elapsed != '1)) ?
                    cooldown_elapsed + TIMER_WIDTH'(1) : cooldown_elapsed;

  assign safety_hit = CW'(cut_cnt)  >= CW'(cfg.safety_limit_ms);
  assign cut_done   = CW'(cut_cnt)  >= CW'(cfg.cut_time_ms);
  assign cool_done  = CW'(cool_cnt) >= CW'(cfg.cooldown_ms);

  always_comb begin
    phase_next            = phase;
    cut_elapsed_next      = cut_elapsed;
    cooldown_elapsed_next = cooldown_elapsed;
    case (phase)
      PH_IDLE: begin
        if (item.press_event) begin
          cut_elapsed_next = '0;
          phase_next       = PH_CUT;
        end
      end
      PH_CUT: begin
        cut_elapsed_next = cut_cnt;
        // safety limit wins over the normal end of cut
        if (safety_hit) begin
          phase_next = PH_FAULT;
        end else if (cut_done) begin
          cooldown_elapsed_next = '0;
          phase_next            = PH_COOLDOWN;
        end
      end
      PH_COOLDOWN: begin
        cooldown_elapsed_next = cool_cnt;
        if (cool_done) begin
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!item.button_held) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_FAULT;
      end
    endcase
  end

  always_comb begin
    result.relay_drive = (phase_next == PH_CUT);
    result.phase_code  = phase_next;
    result.shift_beep  = (phase == PH_IDLE) && item.press_event;
    result.fault_pulse = (phase == PH_CUT) && safety_hit;
  end

endmodule
